### hw/rtl/linear_probe_hash_table_unit_macros.svh
// ---------------------------------------------------------------------------
// Linear probe hash table assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/lpht_pkg.sv
// ---------------------------------------------------------------------------
// Linear probe hash table package
// Table geometry, field widths and result status codes.
// ---------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

   localparam int BUCKET_COUNT = 11;
   localparam int IDX_W        = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

   localparam int KEY_W    = 12;
   localparam int TAG_W    = 8;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 3'd4;

endpackage

`default_nettype wire

### hw/rtl/lpht_home.sv
// ---------------------------------------------------------------------------
// Linear probe hash table home bucket
// Computes key mod BUCKET_COUNT by a registered reciprocal multiply and a
// remainder correction in the following cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module lpht_home
   import lpht_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             load,
   input  wire logic [KEY_W-1:0] key,
   output logic      [IDX_W-1:0] home
);

   localparam int MOD_SHIFT = 24;
   localparam int RECIP     = (1 << MOD_SHIFT) / BUCKET_COUNT + 1;
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int PROD_W    = KEY_W + RECIP_W;

   logic [KEY_W-1:0]  key_ff;
   logic [KEY_W-1:0]  quot_ff;
   logic [KEY_W-1:0]  quot_in;
   logic [PROD_W-1:0] prod;
   logic [KEY_W-1:0]  quot_mul;
   logic [KEY_W-1:0]  diff;

   assign prod    = PROD_W'(key) * PROD_W'(RECIP);
   assign quot_in = KEY_W'(prod >> MOD_SHIFT);

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff  <= key;
         quot_ff <= quot_in;
      end
   end

   assign quot_mul = KEY_W'(quot_ff * KEY_W'(BUCKET_COUNT));
   assign diff     = key_ff - quot_mul;

   always_comb begin
      if (diff >= KEY_W'(BUCKET_COUNT)) begin
         home = IDX_W'(diff - KEY_W'(BUCKET_COUNT));
      end else begin
         home = IDX_W'(diff);
      end
   end

endmodule

`default_nettype wire

### hw/rtl/linear_probe_hash_table_unit.sv
// ---------------------------------------------------------------------------
// Linear probe hash table unit
// Open-addressing table of BUCKET_COUNT buckets with linear probing.
// ---------------------------------------------------------------------------
// One command is taken at a time: a transfer happens when start is high and
// busy is low. A zero key is answered in the next cycle and busy stays low.
// Any other command reads the home bucket in the hash state and then probes
// one bucket per cycle in the probe state, because the key memory has a single
// read port that is visited once per cycle; at most BUCKET_COUNT buckets are
// probed, and the result is registered after the last probe decision.
// Busy falls in the cycle that shows the result, so the next command can
// transfer at the edge that ends it. Each result is shown for exactly one
// cycle with rsp_strobe high and cannot be held off, so it must be captured
// on that edge. Keys are empty from reset on through per-bucket valid flops;
// no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

`include "linear_probe_hash_table_unit_macros.svh"

module linear_probe_hash_table_unit
   import lpht_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_cmd,
   input  wire logic [KEY_W-1:0]    req_key,
   input  wire logic [TAG_W-1:0]    req_tag_in,
   output logic                     rsp_strobe,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [SLOT_W-1:0]   rsp_slot,
   output logic      [TAG_W-1:0]    rsp_tag_out
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_HASH  = 2'd1;
   localparam logic [1:0] S_PROBE = 2'd2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_COUNT - 1);

   logic [1:0]          state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;

   logic [BUCKET_COUNT-1:0] valid_ff;
   logic [KEY_W-1:0]        key_mem [BUCKET_COUNT];
   logic [TAG_W-1:0]        tag_mem [BUCKET_COUNT];
   logic [KEY_W-1:0]        rd_key_ff;
   logic [TAG_W-1:0]        rd_tag_ff;
   logic                    rd_valid_ff;

   logic             accept;
   logic             home_load;
   logic [IDX_W-1:0] home;
   logic [IDX_W-1:0] next_idx;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic             last_probe;
   logic             key_match;

   lpht_home u_home (
      .clock (clock),
      .load  (home_load),
      .key   (req_key),
      .home  (home)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign home_load  = accept && (req_key != '0);
   assign next_idx   = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
   assign last_probe = (cnt_ff == LAST_IDX);
   assign key_match  = rd_valid_ff && (rd_key_ff == key_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      tag_in        = tag_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_NOT_FOUND;
      rsp_slot_in   = '0;
      rsp_tag_in    = '0;
      rd_addr       = next_idx;
      mem_we        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_key == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_ZERO_KEY;
               end else begin
                  cmd_in   = req_cmd;
                  key_in   = req_key;
                  tag_in   = req_tag_in;
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            rd_addr  = home;
            idx_in   = home;
            cnt_in   = '0;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            if (cmd_ff == CMD_INSERT) begin
               if (!rd_valid_ff) begin
                  mem_we        = 1'b1;
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_INSERTED;
                  rsp_slot_in   = SLOT_W'(idx_ff);
                  state_in      = S_IDLE;
               end else if (last_probe) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_FULL;
                  state_in      = S_IDLE;
               end else begin
                  idx_in = next_idx;
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end else begin
               if (key_match) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_FOUND;
                  rsp_slot_in   = SLOT_W'(idx_ff);
                  rsp_tag_in    = rd_tag_ff;
                  state_in      = S_IDLE;
               end else if (last_probe) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_NOT_FOUND;
                  state_in      = S_IDLE;
               end else begin
                  idx_in = next_idx;
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (mem_we) begin
            valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      tag_ff        <= tag_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tag_ff    <= rsp_tag_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[idx_ff] <= key_ff;
         tag_mem[idx_ff] <= tag_ff;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_tag_ff   <= tag_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_tag_out = rsp_tag_ff;

   `LPHT_ASSERT_NEXT(a_key_goes_busy, accept && (req_key != '0), busy,
      "A transfer with a nonzero key did not start a probe.")
   `LPHT_ASSERT_SAME(a_rsp_when_idle, rsp_strobe, !busy,
      "A result was shown while a probe was still running.")
   `LPHT_ASSERT_SAME(a_write_on_insert, mem_we,
      (state_ff == S_PROBE) && (cmd_ff == CMD_INSERT) && !rd_valid_ff,
      "The table was written outside an insert into an empty bucket.")
   `LPHT_ASSERT_SAME(a_probe_bound, state_ff == S_PROBE, cnt_ff <= LAST_IDX,
      "The probe ran past the last bucket.")

endmodule

`default_nettype wire

### verif/linear_probe_hash_table_unit_tb.sv
// ---------------------------------------------------------------------------
// Linear probe hash table unit testbench
// Sends insert and lookup commands over the start/busy port and scores every
// strobed reply against a shadow copy of the table. Directed tests cover zero
// keys, collisions, wraparound, duplicates, misses and a full table. Random
// phases follow with varying sender idle rates.
// ---------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import lpht_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = BUCKET_COUNT + 4;
   localparam int PHASE_ITEMS = 217;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [TAG_W-1:0]    tag;
   } reply_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_cmd;
   logic [KEY_W-1:0]    req_key;
   logic [TAG_W-1:0]    req_tag_in;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [TAG_W-1:0]    rsp_tag_out;

   logic [KEY_W-1:0] shadow_key [BUCKET_COUNT];
   logic [TAG_W-1:0] shadow_tag [BUCKET_COUNT];
   reply_type        reply_fifo [$];
   int               errors;
   int               stall_count;
   int               sender_idle_pct;

   linear_probe_hash_table_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_cmd     (req_cmd),
      .req_key     (req_key),
      .req_tag_in  (req_tag_in),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_slot    (rsp_slot),
      .rsp_tag_out (rsp_tag_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic reply_type probe_table(logic cmd, logic [KEY_W-1:0] key,
                                             logic [TAG_W-1:0] tag);
      reply_type r;
      int        idx;
      r = '0;
      if (key == '0) begin
         r.status = ST_ZERO_KEY;
         return r;
      end
      idx = int'(key) % BUCKET_COUNT;
      if (cmd == CMD_INSERT) begin
         r.status = ST_FULL;
         for (int n = 0; n < BUCKET_COUNT; n++) begin
            if (shadow_key[idx] == '0) begin
               shadow_key[idx] = key;
               shadow_tag[idx] = tag;
               r.status = ST_INSERTED;
               r.slot = SLOT_W'(idx);
               return r;
            end
            idx = (idx + 1) % BUCKET_COUNT;
         end
      end else begin
         r.status = ST_NOT_FOUND;
         for (int n = 0; n < BUCKET_COUNT; n++) begin
            if (shadow_key[idx] == key) begin
               r.status = ST_FOUND;
               r.slot = SLOT_W'(idx);
               r.tag = shadow_tag[idx];
               return r;
            end
            idx = (idx + 1) % BUCKET_COUNT;
         end
      end
      return r;
   endfunction

   function automatic int empty_slots();
      int cnt;
      cnt = 0;
      for (int i = 0; i < BUCKET_COUNT; i++)
         if (shadow_key[i] == '0) cnt++;
      return cnt;
   endfunction

   // Called and returns at a falling edge. Start stays high on return so
   // that commands can follow back to back.
   task automatic send_command(logic cmd, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start      <= 1'b1;
      req_cmd    <= cmd;
      req_key    <= key;
      req_tag_in <= tag;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      reply_fifo.push_back(probe_table(cmd, key, tag));
      @(negedge clock);
   endtask

   task automatic wait_replies_drained();
      start <= 1'b0;
      while (reply_fifo.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic test_zero_key();
      send_command(CMD_LOOKUP, '0, 8'h00);
      send_command(CMD_INSERT, '0, 8'hFF);
   endtask

   task automatic test_empty_lookup();
      send_command(CMD_LOOKUP, 12'd1, 8'hA5);
   endtask

   task automatic test_collision_and_wrap();
      send_command(CMD_INSERT, 12'd4095, 8'hFF);
      send_command(CMD_INSERT, 12'd3, 8'h00);
      send_command(CMD_INSERT, 12'd10, 8'h5A);
      send_command(CMD_INSERT, 12'd21, 8'hC3);
      send_command(CMD_INSERT, 12'd4095, 8'h11);
   endtask

   task automatic test_lookup_hits_and_misses();
      send_command(CMD_LOOKUP, 12'd4095, 8'h00);
      send_command(CMD_LOOKUP, 12'd21, 8'hFF);
      send_command(CMD_LOOKUP, 12'd3, 8'h3C);
      send_command(CMD_LOOKUP, 12'd10, 8'h00);
      send_command(CMD_LOOKUP, 12'd14, 8'h00);
      send_command(CMD_LOOKUP, 12'hAAA, 8'h55);
   endtask

   task automatic test_full_table();
      int empties;
      empties = empty_slots();
      for (int i = 0; i < empties; i++)
         send_command(CMD_INSERT, KEY_W'(14 + 11 * i), TAG_W'(8'h80 + i));
      send_command(CMD_INSERT, 12'd1, 8'h77);
      send_command(CMD_INSERT, 12'hFFF, 8'h00);
      send_command(CMD_LOOKUP, KEY_W'(14 + 11 * (empties - 1)), 8'h00);
      send_command(CMD_LOOKUP, 12'd2, 8'h00);
      wait_replies_drained();
   endtask

   task automatic test_random_traffic(int idle_pct, int count);
      logic             cmd;
      logic [KEY_W-1:0] key;
      int               pick;
      int               sel;
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         cmd = (pick < 20) ? CMD_INSERT : CMD_LOOKUP;
         if (pick >= 95) begin
            key = '0;
            cmd = 1'($urandom_range(1));
         end else if (pick >= 20 && pick < 75) begin
            sel = $urandom_range(BUCKET_COUNT - 1);
            key = (shadow_key[sel] != '0) ? shadow_key[sel] : KEY_W'($urandom_range(4095, 1));
         end else begin
            key = KEY_W'($urandom_range(4095, 1));
         end
         send_command(cmd, key, TAG_W'($urandom_range(255)));
      end
      wait_replies_drained();
   endtask

   always @(posedge clock) begin
      reply_type exp;
      if (!reset && rsp_strobe) begin
         if (reply_fifo.size() == 0) begin
            $display("%0t: unexpected reply status=%0d slot=%0d tag=%0h",
                     $time, rsp_status, rsp_slot, rsp_tag_out);
            errors++;
         end else begin
            exp = reply_fifo.pop_front();
            if (rsp_status !== exp.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp.status, rsp_status);
               errors++;
            end
            if (rsp_slot !== exp.slot) begin
               $display("%0t: slot expected %0d actual %0d", $time, exp.slot, rsp_slot);
               errors++;
            end
            if (rsp_tag_out !== exp.tag) begin
               $display("%0t: tag expected %0h actual %0h", $time, exp.tag, rsp_tag_out);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count + 1 >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("[linear_probe_hash_table_unit] ERROR");
            $finish;
         end
      end
   end

   initial begin
      errors = 0;
      sender_idle_pct = 33;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_INSERT;
      req_key = '0;
      req_tag_in = '0;
      for (int i = 0; i < BUCKET_COUNT; i++) begin
         shadow_key[i] = '0;
         shadow_tag[i] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_zero_key();
      test_empty_lookup();
      test_collision_and_wrap();
      test_lookup_hits_and_misses();
      test_full_table();
      test_random_traffic(33, PHASE_ITEMS);
      test_random_traffic(82, PHASE_ITEMS);
      test_random_traffic(0, PHASE_ITEMS);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (reply_fifo.size() != 0) begin
         $display("%0t: %0d replies never arrived", $time, reply_fifo.size());
         errors++;
      end
      if (errors == 0) begin
         $display("[linear_probe_hash_table_unit] OK");
      end else begin
         $display("[linear_probe_hash_table_unit] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
